// ===== rtl/srt_pkg.sv =====
// Shared constants, codes and types of the sealed range table.
`default_nettype none
package srt_pkg;

  // Payload field widths of the two channels
  localparam int ADDR_FIELD_W = 48;
  localparam int FLAGS_W      = 32;
  localparam int STATUS_W     = 2;

  // Configuration port geometry: 64-bit registers at byte address 8*i
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_ADDR_W = CFG_IDX_W + 3;
  localparam int MAX_UA_W   = 48;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_USER_ADDR = 1'b0;
  localparam logic [MAX_UA_W-1:0]  MAX_USER_ADDR_RST = 48'h8000_0000_0000;

  // Commands
  localparam logic CMD_CHECK = 1'b0;
  localparam logic CMD_SEAL  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVAL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOMEM = 2'd2;

  // One result item as it moves from the sequencer to the output stage
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                sealed;
    logic                merged;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/srt_in_if.sv =====
// Command channel: valid/ready handshake with one command item as payload.
`default_nettype none
interface srt_in_if;
  import srt_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    command;
  logic [ADDR_FIELD_W-1:0] address;
  logic [ADDR_FIELD_W-1:0] length;
  logic [FLAGS_W-1:0]      seal_flags;
  logic                    all_mapped;

  modport source (
    output valid, command, address, length, seal_flags, all_mapped,
    input  ready
  );
  modport sink (
    input  valid, command, address, length, seal_flags, all_mapped,
    output ready
  );
endinterface
`default_nettype wire

// ===== rtl/srt_out_if.sv =====
// Result channel: valid/ready handshake with one result item as payload.
`default_nettype none
interface srt_out_if;
  import srt_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                sealed;
  logic                merged;

  modport source (
    output valid, status, sealed, merged,
    input  ready
  );
  modport sink (
    input  valid, status, sealed, merged,
    output ready
  );
endinterface
`default_nettype wire

// ===== rtl/srt_range_mem.sv =====
// Interval store: one synchronous memory of {start, end} pairs with a registered read.
`default_nettype none
module srt_range_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 48
) (
  input  wire logic                     clk,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_idx,
  output logic      [AW-1:0]            rd_start,
  output logic      [AW-1:0]            rd_end,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_idx,
  input  wire logic [AW-1:0]            wr_start,
  input  wire logic [AW-1:0]            wr_end
);

  logic [2*AW-1:0] mem [DEPTH];
  logic [2*AW-1:0] rd_data_r;

  // Write one entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= {wr_start, wr_end};
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_idx];
    end
  end

  assign rd_start = rd_data_r[2*AW-1:AW];
  assign rd_end   = rd_data_r[AW-1:0];

endmodule
`default_nettype wire

// ===== rtl/srt_ctrl.sv =====
// Command sequencer: range arithmetic, validation and the walk over the interval store.
`default_nettype none
module srt_ctrl #(
  parameter int MAX_RANGES   = 64,
  parameter int PAGE_SHIFT   = 12,
  parameter int ADDRESS_BITS = 48
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  srt_in_if.sink                             in_ch,
  input  wire logic [srt_pkg::MAX_UA_W-1:0]  max_user_addr,
  output logic                               res_valid,
  output srt_pkg::res_t                      res,
  input  wire logic                          res_ready,
  output logic                               mem_rd_en,
  output logic [$clog2(MAX_RANGES)-1:0]      mem_rd_idx,
  input  wire logic [ADDRESS_BITS-1:0]       mem_rd_start,
  input  wire logic [ADDRESS_BITS-1:0]       mem_rd_end,
  output logic                               mem_wr_en,
  output logic [$clog2(MAX_RANGES)-1:0]      mem_wr_idx,
  output logic [ADDRESS_BITS-1:0]            mem_wr_start,
  output logic [ADDRESS_BITS-1:0]            mem_wr_end
);
  import srt_pkg::*;

  localparam int AW   = ADDRESS_BITS;
  localparam int IW   = $clog2(MAX_RANGES);
  localparam int CNTW = $clog2(MAX_RANGES + 1);
  localparam int FW   = (AW < ADDR_FIELD_W) ? AW : ADDR_FIELD_W;
  localparam int CW   = (AW > MAX_UA_W) ? AW : MAX_UA_W;
  localparam logic [AW-1:0]   PMASK    = AW'((65'd1 << PAGE_SHIFT) - 65'd1);
  localparam logic [CNTW-1:0] CNT_FULL = CNTW'(MAX_RANGES);

  typedef enum logic [2:0] {
    S_IDLE, S_CALC, S_VALID, S_SCAN, S_DONE
  } state_t;

  state_t          state_r, state_nxt;
  logic            cmd_r, cmd_nxt;
  logic [AW-1:0]   addr_r, addr_nxt;
  logic [AW-1:0]   len_r, len_nxt;
  logic [AW-1:0]   end_r, end_nxt;
  logic            flags_nz_r, flags_nz_nxt;
  logic            mapped_r, mapped_nxt;
  logic            inval_r, inval_nxt;
  logic [CNTW-1:0] count_r, count_nxt;
  logic [CNTW-1:0] rd_cnt_r, rd_cnt_nxt;
  logic            cmp_vld_r, cmp_vld_nxt;
  logic [IW-1:0]   cmp_idx_r, cmp_idx_nxt;
  res_t            res_r, res_nxt;

  logic [AW:0]     sum_a;
  logic [AW:0]     sum_b;
  logic            hit;
  logic            seal_bad;

  // Range arithmetic shared by the calc and validate steps
  assign sum_a = {1'b0, addr_r} + {1'b0, len_r};
  assign sum_b = {1'b0, len_r} + {1'b0, PMASK};

  assign seal_bad = flags_nz_r || inval_r || (addr_r[PAGE_SHIFT-1:0] != '0) || sum_a[AW] ||
                    (CW'(sum_a[AW-1:0]) > CW'(max_user_addr));

  // Overlap test for checks, touch-or-overlap test for seals
  always_comb begin
    hit = 1'b0;
    if (cmp_vld_r) begin
      if (cmd_r == CMD_SEAL) begin
        hit = (mem_rd_start <= end_r) && (addr_r <= mem_rd_end);
      end else begin
        hit = (mem_rd_start < end_r) && (addr_r < mem_rd_end);
      end
    end
  end

  // Next state and datapath
  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    addr_nxt     = addr_r;
    len_nxt      = len_r;
    end_nxt      = end_r;
    flags_nz_nxt = flags_nz_r;
    mapped_nxt   = mapped_r;
    inval_nxt    = inval_r;
    count_nxt    = count_r;
    rd_cnt_nxt   = rd_cnt_r;
    cmp_vld_nxt  = 1'b0;
    cmp_idx_nxt  = cmp_idx_r;
    res_nxt      = res_r;
    mem_rd_en    = 1'b0;
    mem_rd_idx   = rd_cnt_r[IW-1:0];
    mem_wr_en    = 1'b0;
    mem_wr_idx   = cmp_idx_r;
    mem_wr_start = addr_r;
    mem_wr_end   = end_r;

    case (state_r)
      S_IDLE: begin
        // Capture a command transfer
        if (in_ch.valid) begin
          cmd_nxt      = in_ch.command;
          addr_nxt     = AW'(in_ch.address[FW-1:0]);
          len_nxt      = AW'(in_ch.length[FW-1:0]);
          flags_nz_nxt = (in_ch.seal_flags != '0);
          mapped_nxt   = in_ch.all_mapped;
          state_nxt    = S_CALC;
        end
      end
      S_CALC: begin
        rd_cnt_nxt = '0;
        if (cmd_r == CMD_SEAL) begin
          // Round the length up to whole pages
          inval_nxt = sum_b[AW];
          len_nxt   = sum_b[AW-1:0] & ~PMASK;
          state_nxt = S_VALID;
        end else begin
          // Saturate the check end on overflow
          end_nxt   = sum_a[AW] ? '1 : sum_a[AW-1:0];
          state_nxt = S_SCAN;
        end
      end
      S_VALID: begin
        res_nxt = '{status: ST_OK, sealed: 1'b0, merged: 1'b0};
        end_nxt = sum_a[AW-1:0];
        if (seal_bad) begin
          res_nxt.status = ST_INVAL;
          state_nxt      = S_DONE;
        end else if (len_r == '0) begin
          state_nxt = S_DONE;
        end else if (!mapped_r) begin
          res_nxt.status = ST_NOMEM;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        res_nxt = '{status: ST_OK, sealed: 1'b0, merged: 1'b0};
        // Issue the next read unless this cycle already found a match
        if (!hit && (rd_cnt_r < count_r)) begin
          mem_rd_en   = 1'b1;
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = rd_cnt_r[IW-1:0];
          rd_cnt_nxt  = rd_cnt_r + CNTW'(1);
        end
        if (hit) begin
          if (cmd_r == CMD_SEAL) begin
            // Widen the matching interval
            mem_wr_en      = 1'b1;
            mem_wr_start   = (addr_r < mem_rd_start) ? addr_r : mem_rd_start;
            mem_wr_end     = (end_r > mem_rd_end) ? end_r : mem_rd_end;
            res_nxt.merged = 1'b1;
          end else begin
            res_nxt.sealed = 1'b1;
          end
          state_nxt = S_DONE;
        end else if (!cmp_vld_r && (rd_cnt_r == count_r)) begin
          // Walk finished without a match
          if (cmd_r == CMD_SEAL) begin
            if (count_r == CNT_FULL) begin
              res_nxt.status = ST_NOMEM;
            end else begin
              mem_wr_en  = 1'b1;
              mem_wr_idx = count_r[IW-1:0];
              count_nxt  = count_r + CNTW'(1);
            end
          end
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // Hold the result until the output stage takes it
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      cmp_vld_r <= cmp_vld_nxt;
    end
    cmd_r      <= cmd_nxt;
    addr_r     <= addr_nxt;
    len_r      <= len_nxt;
    end_r      <= end_nxt;
    flags_nz_r <= flags_nz_nxt;
    mapped_r   <= mapped_nxt;
    inval_r    <= inval_nxt;
    rd_cnt_r   <= rd_cnt_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    res_r      <= res_nxt;
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign res_valid   = (state_r == S_DONE);
  assign res         = res_r;

endmodule
`default_nettype wire

// ===== rtl/sealed_range_table_core.sv =====
// Top level of the sealed range table: register port, sequencer, interval store, result stage.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+-----------------------------------------
//  in_ch    | in        | valid/ready             | command, address, length, seal_flags,
//           |           |                         | all_mapped
//  out_ch   | out       | valid/ready             | status, sealed, merged
//  cfg_*    | in        | APB write, pready high  | max_user_address at byte address 0
//
// From one command transfer to the next ready, a check passes through calc, scan and done, and
// a seal through calc, validate, scan and done; a match ends the walk early, and a rejected,
// empty or unmapped seal skips the walk. The walk reads one entry per cycle from the store, so
// the table fill sets the cost.
// Reset clears the interval count and the handshake state; store contents are not cleared.
// A stalled result sits in the output register while the next command is already taken.
`default_nettype none
module sealed_range_table_core #(
  parameter int MAX_RANGES   = 64,
  parameter int PAGE_SHIFT   = 12,
  parameter int ADDRESS_BITS = 48
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  srt_in_if.sink                               in_ch,
  srt_out_if.source                            out_ch,
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [srt_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire logic [srt_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic      [srt_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                                 cfg_pready
);
  import srt_pkg::*;

  localparam int IW = $clog2(MAX_RANGES);

  logic [MAX_UA_W-1:0]     max_ua_r;
  logic                    cfg_sel_reg;
  logic                    res_valid;
  logic                    res_ready;
  res_t                    res;
  logic                    out_valid_r;
  res_t                    out_res_r;
  logic                    mem_rd_en;
  logic [IW-1:0]           mem_rd_idx;
  logic [ADDRESS_BITS-1:0] mem_rd_start;
  logic [ADDRESS_BITS-1:0] mem_rd_end;
  logic                    mem_wr_en;
  logic [IW-1:0]           mem_wr_idx;
  logic [ADDRESS_BITS-1:0] mem_wr_start;
  logic [ADDRESS_BITS-1:0] mem_wr_end;

  // Configuration register
  assign cfg_pready  = 1'b1;
  assign cfg_sel_reg = (cfg_paddr[CFG_ADDR_W-1:3] == REG_MAX_USER_ADDR);
  assign cfg_prdata  = cfg_sel_reg ? CFG_DATA_W'(max_ua_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_ua_r <= MAX_USER_ADDR_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_sel_reg) begin
      max_ua_r <= cfg_pwdata[MAX_UA_W-1:0];
    end
  end

  srt_ctrl #(
    .MAX_RANGES   (MAX_RANGES),
    .PAGE_SHIFT   (PAGE_SHIFT),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .max_user_addr(max_ua_r),
    .res_valid    (res_valid),
    .res          (res),
    .res_ready    (res_ready),
    .mem_rd_en    (mem_rd_en),
    .mem_rd_idx   (mem_rd_idx),
    .mem_rd_start (mem_rd_start),
    .mem_rd_end   (mem_rd_end),
    .mem_wr_en    (mem_wr_en),
    .mem_wr_idx   (mem_wr_idx),
    .mem_wr_start (mem_wr_start),
    .mem_wr_end   (mem_wr_end)
  );

  srt_range_mem #(
    .DEPTH (MAX_RANGES),
    .AW    (ADDRESS_BITS)
  ) u_mem (
    .clk      (clk),
    .rd_en    (mem_rd_en),
    .rd_idx   (mem_rd_idx),
    .rd_start (mem_rd_start),
    .rd_end   (mem_rd_end),
    .wr_en    (mem_wr_en),
    .wr_idx   (mem_wr_idx),
    .wr_start (mem_wr_start),
    .wr_end   (mem_wr_end)
  );

  // Output register: load a finished result whenever the slot is free or drains
  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = out_res_r.status;
  assign out_ch.sealed = out_res_r.sealed;
  assign out_ch.merged = out_res_r.merged;

  // The store is never read and written in the same cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_rd_en && mem_wr_en))
    else $error("interval store read and written in one cycle");

  // The sequencer never offers a result while it takes a new command
  a_ready_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !res_valid)
    else $error("command taken while a result is pending");

  // The sequencer is busy after a command transfer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("sequencer ready right after a command transfer");

  // A handed-over result shows up on the output next cycle
  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_ready) |=> out_ch.valid)
    else $error("result lost between sequencer and output register");

endmodule
`default_nettype wire
